// ===== sv/query_command_tokenizer_assert.svh =====
// ---------------------------------------------------------------------------
// query_command_tokenizer_assert.svh
// assertion macros for the query command tokenizer
// ---------------------------------------------------------------------------
`ifndef QUERY_COMMAND_TOKENIZER_ASSERT_SVH
`define QUERY_COMMAND_TOKENIZER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define QCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define QCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define QCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/qct_pkg.sv =====
// ---------------------------------------------------------------------------
// qct_pkg
// shared types, constants and helpers of the query command tokenizer
// ---------------------------------------------------------------------------
package qct_pkg;

	// sizes
	localparam int MAX_LINE      = 1024;
	localparam int POS_W         = $clog2(MAX_LINE);
	localparam int LEN_W         = POS_W + 1;
	localparam int KEYWORD_CHARS = 6;
	localparam int WORD_W        = 8 * KEYWORD_CHARS;
	localparam int CNT_W         = $clog2(KEYWORD_CHARS + 2);
	localparam int KIND_W        = 6;
	localparam int NUM_KW        = 15;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// token kinds
	typedef enum logic [KIND_W-1:0] {
		K_INT        = 6'd0,
		K_FLOAT      = 6'd1,
		K_STRING     = 6'd2,
		K_CHAR       = 6'd3,
		K_BOOL       = 6'd4,
		K_DATE       = 6'd5,
		K_TIME       = 6'd6,
		K_NEW        = 6'd7,
		K_SCOPE      = 6'd8,
		K_DOT        = 6'd9,
		K_COMMA      = 6'd10,
		K_ADD        = 6'd11,
		K_LBRACK     = 6'd12,
		K_RBRACK     = 6'd13,
		K_LPAREN     = 6'd14,
		K_RPAREN     = 6'd15,
		K_STR_DATA   = 6'd16,
		K_INT_DATA   = 6'd17,
		K_FLOAT_DATA = 6'd18,
		K_TRUE       = 6'd19,
		K_FALSE      = 6'd20,
		K_PRINT      = 6'd21,
		K_REMOVE     = 6'd22,
		K_UPDATE     = 6'd23,
		K_NOT        = 6'd24,
		K_OR         = 6'd25,
		K_AND        = 6'd26,
		K_ARROW      = 6'd27,
		K_EQUAL      = 6'd28,
		K_LESS       = 6'd29,
		K_GREATER    = 6'd30,
		K_LESS_EQ    = 6'd31,
		K_GREATER_EQ = 6'd32,
		K_IDENT      = 6'd33,
		K_EXIT       = 6'd34,
		K_END        = 6'd35
	} tok_kind_t;

	// end item status
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNKNOWN_CHAR = 2'd1,
		ST_UNCLOSED     = 2'd2
	} scan_status_t;

	// one result item
	typedef struct packed {
		tok_kind_t         kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  length;
		scan_status_t      status;
		logic              last;
	} token_t;

	// character codes
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_DASH       = 8'h2D;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_DIGIT_0    = 8'h30;
	localparam logic [7:0] CH_DIGIT_9    = 8'h39;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_LBRACK     = 8'h5B;
	localparam logic [7:0] CH_RBRACK     = 8'h5D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CH_BAR        = 8'h7C;

	// keyword table, text right-aligned with the first character highest
	localparam logic [WORD_W-1:0] KW_TEXT [NUM_KW] = '{
		WORD_W'("int"), WORD_W'("float"), WORD_W'("string"), WORD_W'("char"),
		WORD_W'("bool"), WORD_W'("date"), WORD_W'("time"), WORD_W'("new"),
		WORD_W'("add"), WORD_W'("print"), WORD_W'("remove"), WORD_W'("update"),
		WORD_W'("exit"), WORD_W'("true"), WORD_W'("false")
	};
	localparam logic [CNT_W-1:0] KW_LEN [NUM_KW] = '{
		CNT_W'(3), CNT_W'(5), CNT_W'(6), CNT_W'(4), CNT_W'(4), CNT_W'(4),
		CNT_W'(4), CNT_W'(3), CNT_W'(3), CNT_W'(5), CNT_W'(6), CNT_W'(6),
		CNT_W'(4), CNT_W'(4), CNT_W'(5)
	};
	localparam tok_kind_t KW_KIND [NUM_KW] = '{
		K_INT, K_FLOAT, K_STRING, K_CHAR, K_BOOL, K_DATE, K_TIME, K_NEW,
		K_ADD, K_PRINT, K_REMOVE, K_UPDATE, K_EXIT, K_TRUE, K_FALSE
	};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDERSCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
	endfunction

	// parallel keyword compare
	function automatic tok_kind_t word_kind(input logic [WORD_W-1:0] w,
			input logic [CNT_W-1:0] n);
		tok_kind_t k;
		k = K_IDENT;
		for (int i = 0; i < NUM_KW; i++) begin
			if (n == KW_LEN[i] && w == KW_TEXT[i]) begin
				k = KW_KIND[i];
			end
		end
		return k;
	endfunction

endpackage

// ===== sv/qct_cmd_if.sv =====
// ---------------------------------------------------------------------------
// qct_cmd_if
// command byte channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface qct_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

// ===== sv/qct_tok_if.sv =====
// ---------------------------------------------------------------------------
// qct_tok_if
// token result channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface qct_tok_if;
	import qct_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [POS_W-1:0]  token_start;
	logic [LEN_W-1:0]  token_length;
	logic [1:0]        status;
	logic              last;

	modport source(output valid, output token_kind, output token_start,
		output token_length, output status, output last, input ready);
	modport sink(input valid, input token_kind, input token_start,
		input token_length, input status, input last, output ready);
endinterface

// ===== sv/query_command_tokenizer.sv =====
// ---------------------------------------------------------------------------
// query_command_tokenizer: streaming tokenizer, one command byte per transfer
// results: a byte's results enter the result queue on its transfer and leave in order,
//   behind any older results still waiting in the queue
// throughput: one byte per cycle while the 4-entry result queue has at least 2 free entries
// reset: arst_n clears scanner state and empties the queue at once
// ---------------------------------------------------------------------------
`include "query_command_tokenizer_assert.svh"

module query_command_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	qct_cmd_if.sink   cmd,
	qct_tok_if.source tok
);
	import qct_pkg::*;

	// scanner modes
	typedef enum logic [11:0] {
		M_IDLE   = 12'b0000_0000_0001,
		M_IDENT  = 12'b0000_0000_0010,
		M_NUMBER = 12'b0000_0000_0100,
		M_STRING = 12'b0000_0000_1000,
		M_COLON  = 12'b0000_0001_0000,
		M_BAR    = 12'b0000_0010_0000,
		M_AMP    = 12'b0000_0100_0000,
		M_DASH   = 12'b0000_1000_0000,
		M_EQ     = 12'b0001_0000_0000,
		M_LT     = 12'b0010_0000_0000,
		M_GT     = 12'b0100_0000_0000,
		M_SKIP   = 12'b1000_0000_0000
	} scan_mode_t;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

	scan_mode_t         mode_q;
	logic [WORD_W-1:0]  word_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               dot_q;
	logic [POS_W-1:0]   tb_q;
	logic [POS_W-1:0]   position_q;
	scan_status_t       err_q;
	logic [POS_W-1:0]   errpos_q;

	scan_mode_t         n_mode;
	logic [WORD_W-1:0]  n_word;
	logic [CNT_W-1:0]   n_cnt;
	logic               n_dot;
	logic [POS_W-1:0]   n_tb;
	logic [POS_W-1:0]   n_pos;
	scan_status_t       n_err;
	logic [POS_W-1:0]   n_errpos;

	token_t             r0;
	token_t             r1;
	logic [1:0]         push_cnt;

	token_t             queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  qcnt_q;

	logic               cmd_xfer;
	logic               tok_xfer;
	logic [1:0]         push;

	assign cmd_xfer = cmd.valid && cmd.ready;
	assign tok_xfer = tok.valid && tok.ready;
	assign push     = cmd_xfer ? push_cnt : 2'd0;

	// room for the two results a byte can cause
	assign cmd.ready = qcnt_q <= QCNT_W'(QUEUE_DEPTH - 2);

	// scanner next state and results of the offered byte
	always_comb begin
		logic [7:0]       c;
		logic [POS_W-1:0] cur;
		logic [POS_W-1:0] pos_inc;
		logic [LEN_W-1:0] span_len;
		logic             used;
		logic             e1_vld;
		logic             e2_vld;
		token_t           e1;
		token_t           e2;

		c        = cmd.char_code;
		cur      = position_q;
		pos_inc  = (cur == POS_MAX) ? cur : cur + 1'b1;
		span_len = (cur >= tb_q) ? LEN_W'(cur - tb_q) : '0;
		used     = 1'b0;
		e1_vld   = 1'b0;
		e2_vld   = 1'b0;
		e1       = '0;
		e2       = '0;
		n_mode   = mode_q;
		n_word   = word_q;
		n_cnt    = cnt_q;
		n_dot    = dot_q;
		n_tb     = tb_q;
		n_pos    = pos_inc;
		n_err    = err_q;
		n_errpos = errpos_q;

		// continue or close the open token
		unique case (mode_q)
			M_IDLE: begin
			end
			M_IDENT: begin
				if (is_letter(c) || is_digit(c)) begin
					if (cnt_q < CNT_W'(KEYWORD_CHARS)) begin
						n_word = {word_q[WORD_W-9:0], c};
						n_cnt  = cnt_q + 1'b1;
					end else begin
						n_cnt = CNT_W'(KEYWORD_CHARS + 1);
					end
					used = 1'b1;
				end else begin
					e1_vld    = 1'b1;
					e1.kind   = word_kind(word_q, cnt_q);
					e1.start  = tb_q;
					e1.length = span_len;
					n_mode    = M_IDLE;
				end
			end
			M_NUMBER: begin
				if (is_digit(c) || c == CH_DOT) begin
					if (c == CH_DOT) begin
						n_dot = 1'b1;
					end
					used = 1'b1;
				end else begin
					e1_vld    = 1'b1;
					e1.kind   = dot_q ? K_FLOAT_DATA : K_INT_DATA;
					e1.start  = tb_q;
					e1.length = span_len;
					n_mode    = M_IDLE;
				end
			end
			M_STRING: begin
				if (c == CH_QUOTE || c == CH_NUL) begin
					e1_vld    = 1'b1;
					e1.kind   = K_STR_DATA;
					e1.start  = tb_q;
					e1.length = span_len;
					n_mode    = M_IDLE;
					used      = (c == CH_QUOTE);
					if (c == CH_NUL) begin
						n_err    = ST_UNCLOSED;
						n_errpos = cur;
					end
				end else begin
					used = 1'b1;
				end
			end
			M_COLON, M_BAR, M_AMP, M_DASH, M_EQ: begin
				e1.start  = tb_q;
				e1.length = LEN_W'(2);
				n_mode    = M_IDLE;
				if (mode_q == M_COLON && c == CH_COLON) begin
					e1_vld  = 1'b1;
					e1.kind = K_SCOPE;
				end else if (mode_q == M_BAR && c == CH_BAR) begin
					e1_vld  = 1'b1;
					e1.kind = K_OR;
				end else if (mode_q == M_AMP && c == CH_AMP) begin
					e1_vld  = 1'b1;
					e1.kind = K_AND;
				end else if (mode_q == M_DASH && c == CH_GT) begin
					e1_vld  = 1'b1;
					e1.kind = K_ARROW;
				end else if (mode_q == M_EQ && c == CH_EQ) begin
					e1_vld  = 1'b1;
					e1.kind = K_EQUAL;
				end else begin
					n_err    = ST_UNKNOWN_CHAR;
					n_errpos = cur;
					n_mode   = M_SKIP;
				end
				used = (c != CH_NUL);
			end
			M_LT, M_GT: begin
				e1_vld   = 1'b1;
				e1.start = tb_q;
				n_mode   = M_IDLE;
				if (c == CH_EQ) begin
					e1.kind   = (mode_q == M_LT) ? K_LESS_EQ : K_GREATER_EQ;
					e1.length = LEN_W'(2);
					used      = 1'b1;
				end else begin
					e1.kind   = (mode_q == M_LT) ? K_LESS : K_GREATER;
					e1.length = LEN_W'(1);
				end
			end
			M_SKIP: begin
				used = (c != CH_NUL);
			end
			default: begin
				n_mode = M_IDLE;
			end
		endcase

		// scan the byte as the start of a new token
		if (!used) begin
			e2.start  = cur;
			e2.length = LEN_W'(1);
			if (c == CH_NUL) begin
				// end of command: report status, return to reset state
				e2_vld    = 1'b1;
				e2.kind   = K_END;
				e2.start  = (n_err != ST_OK) ? n_errpos : '0;
				e2.length = '0;
				e2.status = n_err;
				n_mode    = M_IDLE;
				n_word    = '0;
				n_cnt     = '0;
				n_dot     = 1'b0;
				n_tb      = '0;
				n_pos     = '0;
				n_err     = ST_OK;
				n_errpos  = '0;
			end else if (is_letter(c)) begin
				n_mode = M_IDENT;
				n_tb   = cur;
				n_word = WORD_W'(c);
				n_cnt  = CNT_W'(1);
			end else if (is_digit(c)) begin
				n_mode = M_NUMBER;
				n_tb   = cur;
				n_dot  = 1'b0;
			end else begin
				unique case (c)
					CH_SPACE: begin
					end
					CH_QUOTE: begin
						n_mode = M_STRING;
						n_tb   = pos_inc;
					end
					CH_LPAREN: begin
						e2_vld  = 1'b1;
						e2.kind = K_LPAREN;
					end
					CH_RPAREN: begin
						e2_vld  = 1'b1;
						e2.kind = K_RPAREN;
					end
					CH_COMMA: begin
						e2_vld  = 1'b1;
						e2.kind = K_COMMA;
					end
					CH_DOT: begin
						e2_vld  = 1'b1;
						e2.kind = K_DOT;
					end
					CH_LBRACK: begin
						e2_vld  = 1'b1;
						e2.kind = K_LBRACK;
					end
					CH_RBRACK: begin
						e2_vld  = 1'b1;
						e2.kind = K_RBRACK;
					end
					CH_BANG: begin
						e2_vld  = 1'b1;
						e2.kind = K_NOT;
					end
					CH_COLON: begin
						n_mode = M_COLON;
						n_tb   = cur;
					end
					CH_BAR: begin
						n_mode = M_BAR;
						n_tb   = cur;
					end
					CH_AMP: begin
						n_mode = M_AMP;
						n_tb   = cur;
					end
					CH_DASH: begin
						n_mode = M_DASH;
						n_tb   = cur;
					end
					CH_EQ: begin
						n_mode = M_EQ;
						n_tb   = cur;
					end
					CH_LT: begin
						n_mode = M_LT;
						n_tb   = cur;
					end
					CH_GT: begin
						n_mode = M_GT;
						n_tb   = cur;
					end
					default: begin
						n_err    = ST_UNKNOWN_CHAR;
						n_errpos = cur;
						n_mode   = M_SKIP;
					end
				endcase
			end
		end

		// order the results and mark the last one
		r0       = e1_vld ? e1 : e2;
		r1       = e2;
		r0.last  = !(e1_vld && e2_vld);
		r1.last  = 1'b1;
		push_cnt = 2'(e1_vld) + 2'(e2_vld);
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			word_q     <= '0;
			cnt_q      <= '0;
			dot_q      <= 1'b0;
			tb_q       <= '0;
			position_q <= '0;
			err_q      <= ST_OK;
			errpos_q   <= '0;
		end else if (cmd_xfer) begin
			mode_q     <= n_mode;
			word_q     <= n_word;
			cnt_q      <= n_cnt;
			dot_q      <= n_dot;
			tb_q       <= n_tb;
			position_q <= n_pos;
			err_q      <= n_err;
			errpos_q   <= n_errpos;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			queue_q[wr_ptr_q] <= r0;
		end
		if (push == 2'd2) begin
			queue_q[wr_ptr_q + 1'b1] <= r1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			qcnt_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(tok_xfer);
			qcnt_q   <= qcnt_q + QCNT_W'(push) - QCNT_W'(tok_xfer);
		end
	end

	// output side
	assign tok.valid        = qcnt_q != '0;
	assign tok.token_kind   = queue_q[rd_ptr_q].kind;
	assign tok.token_start  = queue_q[rd_ptr_q].start;
	assign tok.token_length = queue_q[rd_ptr_q].length;
	assign tok.status       = queue_q[rd_ptr_q].status;
	assign tok.last         = queue_q[rd_ptr_q].last;

	// checks
	`QCT_ASSERT_NEXT(a_end_clears_state, clk, arst_n, cmd_xfer && cmd.char_code == CH_NUL, mode_q == M_IDLE && position_q == '0 && err_q == ST_OK, "end of command did not clear scanner state")
	`QCT_ASSERT_NEXT(a_end_yields_result, clk, arst_n, cmd_xfer && cmd.char_code == CH_NUL, tok.valid, "end of command produced no result")
	`QCT_ASSERT_NOW(a_skip_has_error, clk, arst_n, mode_q == M_SKIP, err_q == ST_UNKNOWN_CHAR, "skip mode without error status")
	`QCT_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, qcnt_q <= QCNT_W'(QUEUE_DEPTH), "result queue overflow")

endmodule

// ===== bench/tb_query_command_tokenizer.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_query_command_tokenizer
// Feeds command bytes to the tokenizer and checks every token it returns.
// A short table of hand-picked bytes comes first, then random commands,
// mostly well-formed with some noise. A scanner model in the bench predicts
// the tokens, and the returned tokens are compared in order, one field at
// a time.
// ---------------------------------------------------------------------------
module tb_query_command_tokenizer;
	import qct_pkg::*;

	localparam int RANDOM_BYTES = 320;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;

	// one command byte, with an optional hand-written expected token
	typedef struct packed {
		logic [7:0] code;
		logic       fixed;
		token_t     fixed_token;
	} cmd_byte_t;

	typedef enum int {
		SM_IDLE, SM_WORD, SM_NUMBER, SM_STRING, SM_COLON, SM_BAR, SM_AMP,
		SM_DASH, SM_EQ, SM_LT, SM_GT, SM_SKIP
	} scan_mode_t;

	localparam token_t NO_TOKEN = '0;

	// hand-picked bytes, expected token written in only where it is obvious
	localparam cmd_byte_t DIRECTED_BYTES [24] = '{
		{CH_LPAREN, 1'b1, {K_LPAREN, 10'd0, 11'd1, ST_OK, 1'b1}},
		{CH_RPAREN, 1'b1, {K_RPAREN, 10'd1, 11'd1, ST_OK, 1'b1}},
		{CH_LT, 1'b0, NO_TOKEN},
		// lone less-than followed by a word start
		{CH_LOWER_A, 1'b0, NO_TOKEN},
		// top byte value ends the word and is an unknown character
		{8'hFF, 1'b0, NO_TOKEN},
		{CH_BANG, 1'b0, NO_TOKEN},
		{CH_NUL, 1'b1, {K_END, 10'd4, 11'd0, ST_UNKNOWN_CHAR, 1'b1}},
		// unclosed string
		{CH_QUOTE, 1'b0, NO_TOKEN},
		{CH_LOWER_A, 1'b0, NO_TOKEN},
		{CH_NUL, 1'b0, NO_TOKEN},
		{CH_BAR, 1'b0, NO_TOKEN},
		{CH_BAR, 1'b1, {K_OR, 10'd0, 11'd2, ST_OK, 1'b1}},
		{CH_DIGIT_9, 1'b0, NO_TOKEN},
		{CH_DOT, 1'b0, NO_TOKEN},
		{CH_AMP, 1'b0, NO_TOKEN},
		{CH_AMP, 1'b1, {K_AND, 10'd4, 11'd2, ST_OK, 1'b1}},
		{CH_GT, 1'b0, NO_TOKEN},
		{CH_EQ, 1'b1, {K_GREATER_EQ, 10'd6, 11'd2, ST_OK, 1'b1}},
		// dash without its partner
		{CH_DASH, 1'b0, NO_TOKEN},
		{CH_EQ, 1'b0, NO_TOKEN},
		{CH_NUL, 1'b1, {K_END, 10'd9, 11'd0, ST_UNKNOWN_CHAR, 1'b1}},
		{CH_NUL, 1'b1, {K_END, 10'd0, 11'd0, ST_OK, 1'b1}},
		// equals cut off by the end of the command
		{CH_EQ, 1'b0, NO_TOKEN},
		{CH_NUL, 1'b1, {K_END, 10'd1, 11'd0, ST_UNKNOWN_CHAR, 1'b1}}
	};

	string keyword_words [15] = '{
		"int", "float", "string", "char", "bool", "date", "time", "new",
		"add", "print", "remove", "update", "exit", "true", "false"
	};
	string operator_texts [16] = '{
		"(", ")", ",", ".", "[", "]", "!", "::", "||", "&&", "->", "==",
		"<", "<=", ">", ">="
	};
	logic [7:0] lone_chars [5] = '{CH_COLON, CH_BAR, CH_AMP, CH_DASH, CH_EQ};

	logic clk = 1'b0;
	logic arst_n;

	qct_cmd_if cmd_bus();
	qct_tok_if tok_bus();

	query_command_tokenizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.tok(tok_bus)
	);

	always #5 clk = ~clk;

	cmd_byte_t cmd_stream [$];
	token_t    expected_tokens [$];
	int        bytes_taken = 0;
	int        mismatch_count = 0;

	// scanner state of the predictor
	scan_mode_t        sc_mode;
	logic [WORD_W-1:0] sc_word;
	int                sc_word_len;
	logic              sc_dot;
	int                sc_begin;
	int                sc_pos;
	scan_status_t      sc_err;
	int                sc_err_pos;
	token_t            scan_out [3];
	int                scan_n;

	// queue appends
	function automatic void append_cmd_byte(input cmd_byte_t b);
		cmd_stream = {cmd_stream, b};
	endfunction

	function automatic void expect_token(input token_t t);
		expected_tokens = {expected_tokens, t};
	endfunction

	function automatic void clear_scanner();
		sc_mode = SM_IDLE;
		sc_word = '0;
		sc_word_len = 0;
		sc_dot = 1'b0;
		sc_begin = 0;
		sc_pos = 0;
		sc_err = ST_OK;
		sc_err_pos = 0;
	endfunction

	function automatic int sat_line(input int v);
		return (v >= MAX_LINE - 1) ? MAX_LINE - 1 : v;
	endfunction

	function automatic int run_length(input int cur);
		return (cur >= sc_begin) ? cur - sc_begin : 0;
	endfunction

	function automatic logic is_word_start(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			|| c == CH_UNDERSCORE;
	endfunction

	function automatic logic is_digit_char(input logic [7:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
	endfunction

	function automatic void emit_token(input tok_kind_t k, input int start, input int len,
			input scan_status_t st);
		if (scan_n < 3) begin
			scan_out[scan_n] = {k, POS_W'(start), LEN_W'(len), st, 1'b0};
			scan_n++;
		end
	endfunction

	// only the first few characters are kept, a longer word never matches
	function automatic void add_word_char(input logic [7:0] c);
		if (sc_word_len < KEYWORD_CHARS) begin
			sc_word = {sc_word[WORD_W-9:0], c};
			sc_word_len++;
		end else begin
			sc_word_len = KEYWORD_CHARS + 1;
		end
	endfunction

	function automatic tok_kind_t keyword_kind();
		if (sc_word_len > KEYWORD_CHARS) begin
			return K_IDENT;
		end
		case (sc_word)
			WORD_W'("int"):    return K_INT;
			WORD_W'("float"):  return K_FLOAT;
			WORD_W'("string"): return K_STRING;
			WORD_W'("char"):   return K_CHAR;
			WORD_W'("bool"):   return K_BOOL;
			WORD_W'("date"):   return K_DATE;
			WORD_W'("time"):   return K_TIME;
			WORD_W'("new"):    return K_NEW;
			WORD_W'("add"):    return K_ADD;
			WORD_W'("print"):  return K_PRINT;
			WORD_W'("remove"): return K_REMOVE;
			WORD_W'("update"): return K_UPDATE;
			WORD_W'("exit"):   return K_EXIT;
			WORD_W'("true"):   return K_TRUE;
			WORD_W'("false"):  return K_FALSE;
			default:           return K_IDENT;
		endcase
	endfunction

	function automatic void flag_error(input int pos);
		sc_err = ST_UNKNOWN_CHAR;
		sc_err_pos = pos;
		sc_mode = SM_SKIP;
	endfunction

	// advance the scanner by one byte, tokens land in scan_out
	function automatic void scan_byte(input logic [7:0] c);
		int cur;
		logic used;
		logic [7:0] partner;
		tok_kind_t pair_k;
		cur = sc_pos;
		used = 1'b0;
		scan_n = 0;
		partner = CH_NUL;
		pair_k = K_SCOPE;

		// continue the token in progress
		case (sc_mode)
			SM_WORD: begin
				if (is_word_start(c) || is_digit_char(c)) begin
					add_word_char(c);
					used = 1'b1;
				end else begin
					emit_token(keyword_kind(), sc_begin, run_length(cur), ST_OK);
					sc_mode = SM_IDLE;
				end
			end
			SM_NUMBER: begin
				if (is_digit_char(c) || c == CH_DOT) begin
					if (c == CH_DOT) begin
						sc_dot = 1'b1;
					end
					used = 1'b1;
				end else begin
					emit_token(sc_dot ? K_FLOAT_DATA : K_INT_DATA, sc_begin, run_length(cur), ST_OK);
					sc_mode = SM_IDLE;
				end
			end
			SM_STRING: begin
				if (c == CH_QUOTE) begin
					emit_token(K_STR_DATA, sc_begin, run_length(cur), ST_OK);
					sc_mode = SM_IDLE;
					used = 1'b1;
				end else if (c == CH_NUL) begin
					emit_token(K_STR_DATA, sc_begin, run_length(cur), ST_OK);
					sc_err = ST_UNCLOSED;
					sc_err_pos = cur;
					sc_mode = SM_IDLE;
				end else begin
					used = 1'b1;
				end
			end
			SM_COLON, SM_BAR, SM_AMP, SM_DASH, SM_EQ: begin
				case (sc_mode)
					SM_COLON: begin partner = CH_COLON; pair_k = K_SCOPE; end
					SM_BAR:   begin partner = CH_BAR;   pair_k = K_OR;    end
					SM_AMP:   begin partner = CH_AMP;   pair_k = K_AND;   end
					SM_DASH:  begin partner = CH_GT;    pair_k = K_ARROW; end
					default:  begin partner = CH_EQ;    pair_k = K_EQUAL; end
				endcase
				if (c == partner) begin
					emit_token(pair_k, sc_begin, 2, ST_OK);
					sc_mode = SM_IDLE;
				end else begin
					flag_error(cur);
				end
				used = (c != CH_NUL);
			end
			SM_LT, SM_GT: begin
				if (c == CH_EQ) begin
					emit_token((sc_mode == SM_LT) ? K_LESS_EQ : K_GREATER_EQ, sc_begin, 2, ST_OK);
					used = 1'b1;
				end else begin
					emit_token((sc_mode == SM_LT) ? K_LESS : K_GREATER, sc_begin, 1, ST_OK);
				end
				sc_mode = SM_IDLE;
			end
			SM_SKIP: begin
				used = (c != CH_NUL);
			end
			default: begin
				sc_mode = SM_IDLE;
			end
		endcase

		// byte not consumed: end of command or start of a new token
		if (!used) begin
			if (c == CH_NUL) begin
				emit_token(K_END, (sc_err != ST_OK) ? sc_err_pos : 0, 0, sc_err);
				clear_scanner();
				scan_out[scan_n-1].last = 1'b1;
				return;
			end
			if (is_word_start(c)) begin
				sc_mode = SM_WORD;
				sc_begin = cur;
				sc_word = '0;
				sc_word_len = 0;
				add_word_char(c);
			end else if (is_digit_char(c)) begin
				sc_mode = SM_NUMBER;
				sc_begin = cur;
				sc_dot = 1'b0;
			end else begin
				case (c)
					CH_SPACE: ;
					CH_QUOTE: begin sc_mode = SM_STRING; sc_begin = sat_line(cur + 1); end
					CH_LPAREN: emit_token(K_LPAREN, cur, 1, ST_OK);
					CH_RPAREN: emit_token(K_RPAREN, cur, 1, ST_OK);
					CH_COMMA:  emit_token(K_COMMA, cur, 1, ST_OK);
					CH_DOT:    emit_token(K_DOT, cur, 1, ST_OK);
					CH_LBRACK: emit_token(K_LBRACK, cur, 1, ST_OK);
					CH_RBRACK: emit_token(K_RBRACK, cur, 1, ST_OK);
					CH_BANG:   emit_token(K_NOT, cur, 1, ST_OK);
					CH_COLON:  begin sc_mode = SM_COLON; sc_begin = cur; end
					CH_BAR:    begin sc_mode = SM_BAR;   sc_begin = cur; end
					CH_AMP:    begin sc_mode = SM_AMP;   sc_begin = cur; end
					CH_DASH:   begin sc_mode = SM_DASH;  sc_begin = cur; end
					CH_EQ:     begin sc_mode = SM_EQ;    sc_begin = cur; end
					CH_LT:     begin sc_mode = SM_LT;    sc_begin = cur; end
					CH_GT:     begin sc_mode = SM_GT;    sc_begin = cur; end
					default:   flag_error(cur);
				endcase
			end
		end

		sc_pos = sat_line(cur + 1);
		if (scan_n > 0) begin
			scan_out[scan_n-1].last = 1'b1;
		end
	endfunction

	// stimulus building
	function automatic void push_char(input logic [7:0] c);
		append_cmd_byte({c, 1'b0, NO_TOKEN});
	endfunction

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
	endfunction

	function automatic logic [7:0] rand_word_start();
		case ($urandom_range(0, 4))
			0:       return CH_UNDERSCORE;
			1, 2:    return 8'(CH_UPPER_A + $urandom_range(0, 25));
			default: return 8'(CH_LOWER_A + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_word_char();
		if ($urandom_range(0, 3) == 0) begin
			return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
		end
		return rand_word_start();
	endfunction

	// any byte except the terminator and the quote
	function automatic logic [7:0] rand_string_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic void append_random_token();
		int pick;
		int n;
		string s;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			// keyword, sometimes one character off or in the wrong case
			s = keyword_words[$urandom_range(0, 14)];
			case ($urandom_range(0, 5))
				0:       s = {s, "x"};
				1:       s = s.substr(0, s.len() - 2);
				2:       s = s.toupper();
				default: ;
			endcase
			append_text(s);
		end else if (pick < 37) begin
			n = $urandom_range(1, 9);
			push_char(rand_word_start());
			for (int i = 1; i < n; i++) begin
				push_char(rand_word_char());
			end
		end else if (pick < 52) begin
			n = $urandom_range(1, 6);
			push_char(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
			for (int i = 1; i < n; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					push_char(CH_DOT);
				end else begin
					push_char(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
				end
			end
		end else if (pick < 65) begin
			n = $urandom_range(0, 8);
			push_char(CH_QUOTE);
			repeat (n) push_char(rand_string_char());
			push_char(CH_QUOTE);
		end else begin
			append_text(operator_texts[$urandom_range(0, 15)]);
		end
		// separator, sometimes none
		n = $urandom_range(0, 9);
		if (n < 6) begin
			push_char(CH_SPACE);
		end else if (n < 7) begin
			repeat ($urandom_range(2, 4)) push_char(CH_SPACE);
		end
	endfunction

	function automatic void append_noise();
		case ($urandom_range(0, 3))
			0: push_char(8'($urandom_range(1, 255)));
			1: begin
				push_char(lone_chars[$urandom_range(0, 4)]);
				push_char(8'($urandom_range(1, 255)));
			end
			2: begin
				push_char(lone_chars[$urandom_range(0, 4)]);
				push_char(CH_SPACE);
			end
			default: push_char(8'(8'h80 + $urandom_range(0, 127)));
		endcase
	endfunction

	function automatic void append_random_command();
		int flavor;
		int ntok;
		int noise_at;
		flavor = $urandom_range(0, 99);
		if (flavor < 4) begin
			push_char(CH_NUL);
			return;
		end
		ntok = $urandom_range(1, 8);
		noise_at = (flavor < 20) ? $urandom_range(0, ntok - 1) : -1;
		for (int i = 0; i < ntok; i++) begin
			if (i == noise_at) begin
				append_noise();
			end
			append_random_token();
		end
		// string left open at the end of the command
		if (flavor >= 20 && flavor < 28) begin
			push_char(CH_QUOTE);
			repeat ($urandom_range(0, 6)) push_char(rand_string_char());
		end
		push_char(CH_NUL);
	endfunction

	function automatic void build_stimulus();
		int rand_bytes;
		int mark;
		foreach (DIRECTED_BYTES[i]) begin
			append_cmd_byte(DIRECTED_BYTES[i]);
		end
		rand_bytes = 0;
		while (rand_bytes < RANDOM_BYTES) begin
			mark = cmd_stream.size();
			append_random_command();
			rand_bytes += cmd_stream.size() - mark;
		end
	endfunction

	function automatic void note_failure(input string what, input token_t want, input token_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$write("%0t %s: expected kind %0d start %0d length %0d status %0d last %0d, ",
				$realtime, what, want.kind, want.start, want.length, want.status, want.last);
			$display("got kind %0d start %0d length %0d status %0d last %0d",
				got.kind, got.start, got.length, got.status, got.last);
		end
	endfunction

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// byte sender: bursts with random gaps
	initial begin : byte_sender
		int burst_left;
		int gap;
		cmd_bus.valid <= 1'b0;
		cmd_bus.char_code <= CH_NUL;
		clear_scanner();
		build_stimulus();
		wait (arst_n === 1'b1);
		@(posedge clk);
		burst_left = 0;
		for (int i = 0; i < cmd_stream.size(); i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					cmd_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			cmd_bus.valid <= 1'b1;
			cmd_bus.char_code <= cmd_stream[i].code;
			@(posedge clk);
			while (cmd_bus.ready !== 1'b1) @(posedge clk);
		end
		cmd_bus.valid <= 1'b0;

		// drain the remaining tokens
		while (bytes_taken != cmd_stream.size() || expected_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// token receiver: stall pattern redrawn every phase, some phases at full rate
	initial begin : token_receiver
		int phase_left;
		int bit_idx;
		logic [15:0] stall_mask;
		logic full_rate;
		tok_bus.ready <= 1'b0;
		phase_left = 0;
		bit_idx = 0;
		stall_mask = 16'hFFFF;
		full_rate = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 200);
				full_rate = ($urandom_range(0, 3) == 0);
				stall_mask = 16'($urandom()) | 16'h0001;
			end
			phase_left--;
			bit_idx = (bit_idx + 1) % 16;
			tok_bus.ready <= full_rate | stall_mask[bit_idx];
		end
	end

	// predict on each byte transfer, compare on each token transfer
	always @(posedge clk) begin : token_checker
		cmd_byte_t item;
		token_t got;
		token_t want;
		if (arst_n === 1'b1) begin
			if (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) begin
				item = cmd_stream[bytes_taken];
				scan_byte(cmd_bus.char_code);
				if (item.fixed) begin
					expect_token(item.fixed_token);
				end else begin
					for (int i = 0; i < scan_n; i++) begin
						expect_token(scan_out[i]);
					end
				end
				bytes_taken++;
			end
			if (tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1) begin
				got = {tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length,
					tok_bus.status, tok_bus.last};
				if (expected_tokens.size() == 0) begin
					note_failure("unexpected token", NO_TOKEN, got);
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind || got.start !== want.start
							|| got.length !== want.length || got.status !== want.status
							|| got.last !== want.last) begin
						note_failure("token mismatch", want, got);
					end
				end
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#(5_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== query_command_tokenizer.f =====
+incdir+sv
sv/qct_pkg.sv
sv/qct_cmd_if.sv
sv/qct_tok_if.sv
sv/query_command_tokenizer.sv
bench/tb_query_command_tokenizer.sv
